// ----- hw/rtl/ssae_pkg.sv -----
// Shared types and constants for the sorted set algebra engine.
// No dependencies; used by sorted_set_algebra_engine_unit (ssae_ram does not use it).
package ssae_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [1:0] OP_UNION = 2'd0;
    localparam logic [1:0] OP_INTER = 2'd1;
    localparam logic [1:0] OP_DIFF  = 2'd2;
    localparam logic [1:0] OP_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0]         op;
        logic               has_value;
        logic signed [31:0] value;
        logic               last;
    } ssae_in_t;

    typedef struct packed {
        logic signed [31:0] element;
        logic               empty_res;
        logic               overflow;
        logic               end_of_list;
    } ssae_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_ACT,
        ST_INS_RD,
        ST_INS_WR,
        ST_DEL_RD,
        ST_DEL_WR,
        ST_FINISH,
        ST_PACK_RD,
        ST_PACK_WR,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_WAIT
    } ssae_state_t;

endpackage

// ----- hw/rtl/sorted_set_algebra_engine_unit.sv -----
// Sorted set algebra engine: keeps an ascending duplicate-free set of signed
// 32-bit values in a RAM and applies union, intersection and difference
// requests to it one element at a time, listing the set after the closing
// request. Depends on ssae_pkg and ssae_ram.
//
// One request at a time; in_ready is high only while the engine is idle. A
// request with an element walks the member RAM through its single read port,
// past the members below the value and then, on an insert or remove, over
// the members that shift. The members walked below the value and the members
// shifted above it together cover the set. A closing request then compacts
// the set (intersection only, keeping the members that were matched) and
// lists it one result at a time, holding each result while the sink stalls.
// Results are held in an output register until taken.
module sorted_set_algebra_engine_unit
    import ssae_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  ssae_in_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output ssae_out_t out_data
);

    ssae_state_t          state_reg, state_next;
    ssae_in_t             item_reg, item_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]     pos_reg, pos_next;
    logic [CNT_W-1:0]     wr_reg, wr_next;
    logic                 found_reg, found_next;
    logic                 ovf_reg, ovf_next;
    logic [CAPACITY-1:0]  mark_reg, mark_next;
    ssae_out_t            out_reg, out_next;
    logic                 out_valid_reg, out_valid_next;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
    logic [31:0]          ram_wdata, ram_rdata;

    logic [CNT_W-1:0]     idx_dec, idx_inc, cnt_dec;
    logic                 in_fire, out_fire, rd_below;

    assign idx_dec  = idx_reg - CNT_W'(1);
    assign idx_inc  = idx_reg + CNT_W'(1);
    assign cnt_dec  = cnt_reg - CNT_W'(1);
    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid_reg && out_ready;
    assign rd_below = $signed(ram_rdata) < item_reg.value;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    ssae_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_members (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_data.has_value && in_data.op != OP_SPARE)
                        state_next = ST_SRCH_RD;
                    else
                        state_next = ST_FINISH;
                end
            end
            ST_SRCH_RD:
                state_next = (idx_reg == cnt_reg) ? ST_ACT : ST_SRCH_CMP;
            ST_SRCH_CMP:
                state_next = rd_below ? ST_SRCH_RD : ST_ACT;
            ST_ACT:
            begin
                state_next = ST_FINISH;
                if (item_reg.op == OP_UNION && !found_reg
                    && cnt_reg < CNT_W'(CAPACITY))
                    state_next = ST_INS_RD;
                else if (item_reg.op == OP_DIFF && found_reg)
                    state_next = ST_DEL_RD;
            end
            ST_INS_RD:
                state_next = (idx_reg == pos_reg) ? ST_FINISH : ST_INS_WR;
            ST_INS_WR:
                state_next = ST_INS_RD;
            ST_DEL_RD:
                state_next = (idx_inc >= cnt_reg) ? ST_FINISH : ST_DEL_WR;
            ST_DEL_WR:
                state_next = ST_DEL_RD;
            ST_FINISH:
            begin
                if (!item_reg.last)
                    state_next = ST_IDLE;
                else if (item_reg.op == OP_INTER)
                    state_next = ST_PACK_RD;
                else
                    state_next = ST_EMIT_RD;
            end
            ST_PACK_RD:
            begin
                if (idx_reg == cnt_reg)
                    state_next = ST_EMIT_RD;
                else if (mark_reg[idx_reg[ADDR_W-1:0]])
                    state_next = ST_PACK_WR;
            end
            ST_PACK_WR:
                state_next = ST_PACK_RD;
            ST_EMIT_RD:
                state_next = (cnt_reg == '0) ? ST_EMIT_WAIT : ST_EMIT_LD;
            ST_EMIT_LD:
                state_next = ST_EMIT_WAIT;
            ST_EMIT_WAIT:
            begin
                if (out_fire)
                    state_next = out_reg.end_of_list ? ST_IDLE : ST_EMIT_RD;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and RAM controls
    always_comb
    begin
        item_next      = item_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        wr_next        = wr_reg;
        found_next     = found_reg;
        ovf_next       = ovf_reg;
        mark_next      = mark_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg[ADDR_W-1:0];
        ram_wdata      = ram_rdata;
        ram_raddr      = idx_reg[ADDR_W-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    item_next  = in_data;
                    idx_next   = '0;
                    found_next = 1'b0;
                end
            end
            ST_SRCH_CMP:
            begin
                if (rd_below)
                    idx_next = idx_inc;
                else
                    found_next = ($signed(ram_rdata) == item_reg.value);
            end
            ST_ACT:
            begin
                pos_next = idx_reg;
                if (item_reg.op == OP_UNION && !found_reg)
                begin
                    if (cnt_reg < CNT_W'(CAPACITY))
                        idx_next = cnt_reg;
                    else
                        ovf_next = 1'b1;
                end
                else if (item_reg.op == OP_INTER && found_reg)
                    mark_next[idx_reg[ADDR_W-1:0]] = 1'b1;
            end
            ST_INS_RD:
            begin
                if (idx_reg == pos_reg)
                begin
                    ram_we                          = 1'b1;
                    ram_wdata                       = item_reg.value;
                    mark_next[idx_reg[ADDR_W-1:0]]  = 1'b0;
                    cnt_next                        = cnt_reg + CNT_W'(1);
                end
                else
                    ram_raddr = idx_dec[ADDR_W-1:0];
            end
            ST_INS_WR:
            begin
                ram_we = 1'b1;
                mark_next[idx_reg[ADDR_W-1:0]] = mark_reg[idx_dec[ADDR_W-1:0]];
                idx_next = idx_dec;
            end
            ST_DEL_RD:
            begin
                if (idx_inc >= cnt_reg)
                begin
                    cnt_next                        = cnt_dec;
                    mark_next[cnt_dec[ADDR_W-1:0]]  = 1'b0;
                end
                else
                    ram_raddr = idx_inc[ADDR_W-1:0];
            end
            ST_DEL_WR:
            begin
                ram_we = 1'b1;
                mark_next[idx_reg[ADDR_W-1:0]] = mark_reg[idx_inc[ADDR_W-1:0]];
                idx_next = idx_inc;
            end
            ST_FINISH:
            begin
                idx_next = '0;
                wr_next  = '0;
            end
            ST_PACK_RD:
            begin
                if (idx_reg == cnt_reg)
                begin
                    cnt_next = wr_reg;
                    idx_next = '0;
                end
                else if (!mark_reg[idx_reg[ADDR_W-1:0]])
                    idx_next = idx_inc;
            end
            ST_PACK_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = wr_reg[ADDR_W-1:0];
                wr_next   = wr_reg + CNT_W'(1);
                idx_next  = idx_inc;
            end
            ST_EMIT_RD:
            begin
                if (cnt_reg == '0)
                begin
                    out_next.element     = '0;
                    out_next.empty_res   = 1'b1;
                    out_next.overflow    = ovf_reg;
                    out_next.end_of_list = 1'b1;
                    out_valid_next       = 1'b1;
                end
            end
            ST_EMIT_LD:
            begin
                out_next.element     = $signed(ram_rdata);
                out_next.empty_res   = 1'b0;
                out_next.overflow    = ovf_reg;
                out_next.end_of_list = (idx_inc == cnt_reg);
                out_valid_next       = 1'b1;
            end
            ST_EMIT_WAIT:
            begin
                if (out_fire)
                begin
                    out_valid_next = 1'b0;
                    idx_next       = idx_inc;
                    if (out_reg.end_of_list)
                    begin
                        mark_next = '0;
                        ovf_next  = 1'b0;
                    end
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            mark_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ovf_reg       <= ovf_next;
            mark_reg      <= mark_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        idx_reg   <= idx_next;
        pos_reg   <= pos_next;
        wr_reg    <= wr_next;
        found_reg <= found_next;
        out_reg   <= out_next;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(CAPACITY))
        else $error("member count above capacity");

    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("request taken while a result is pending");

    a_empty_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.empty_res |-> out_data.end_of_list)
        else $error("empty marker not closing the listing");

    a_list_cont: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.end_of_list |=> !in_ready)
        else $error("listing ended early");

    a_ovf_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_data.end_of_list |=> !ovf_reg && mark_reg == '0)
        else $error("per-command state not cleared after listing");

endmodule

// ----- hw/rtl/ssae_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ssae_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
